// ===== design/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation unit: register indexes,
// register reset values, channel field widths and mode codes.
// ----------------------------------------------------------------------------
package mexp_pkg;

   // configuration register indexes
   localparam logic [7:0] REG_MODULUS     = 8'd0;
   localparam logic [7:0] REG_PUBLIC_EXP  = 8'd1;
   localparam logic [7:0] REG_PRIVATE_EXP = 8'd2;

   // register reset values
   localparam logic [31:0] MODULUS_RESET     = 32'd3233;
   localparam logic [31:0] PUBLIC_EXP_RESET  = 32'd17;
   localparam logic [31:0] PRIVATE_EXP_RESET = 32'd2753;

   // field widths
   localparam int VALUE_BITS  = 32;
   localparam int RESULT_BITS = 32;
   localparam int BYTE_BITS   = 8;
   localparam int CSR_BITS    = 32;

   // mode codes
   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

endpackage

// ===== design/mexp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_cell
// One step of shift-and-add modular multiplication: doubles the partial
// product modulo m, adds the multiplicand when its multiplier bit is set,
// and hands the registered partial product to the next cell.
// ----------------------------------------------------------------------------
module mexp_cell #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         vld_i,
   input  logic [W-1:0] acc_i,
   input  logic [W-1:0] a_i,
   input  logic [W-1:0] m_i,
   input  logic         bit_i,
   output logic         vld_o,
   output logic [W-1:0] acc_o
);

   logic         vld_ff;
   logic [W-1:0] acc_ff;
   logic [W-1:0] acc_in;
   logic [W-1:0] dbl_room;
   logic [W-1:0] dbl;
   logic [W-1:0] add_room;
   logic [W-1:0] sum;

   // double then conditionally add, each kept below m without overflow
   always_comb begin
      dbl_room = m_i - acc_i;
      dbl      = (acc_i >= dbl_room) ? (acc_i - dbl_room) : (acc_i + acc_i);
      add_room = m_i - a_i;
      sum      = (dbl >= add_room) ? (dbl - add_room) : (dbl + a_i);
      acc_in   = bit_i ? sum : dbl;
   end

   // advance the partial product one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_i;
      end
      acc_ff <= acc_in;
   end

   assign vld_o = vld_ff;
   assign acc_o = acc_ff;

endmodule

// ===== design/mexp_mul_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mul_row
// Modular multiplier as a row of N cells. Operands are captured on start;
// the partial product walks the row from the top multiplier bit down, one
// cell per cycle, and the product appears at the output of the last cell.
// ----------------------------------------------------------------------------
module mexp_mul_row #(
   parameter int W = 32,
   parameter int N = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [N-1:0] b,
   input  logic [W-1:0] m,
   output logic         done,
   output logic [W-1:0] prod
);

   logic         go_ff;
   logic [W-1:0] a_ff;
   logic [N-1:0] b_ff;
   logic [W-1:0] m_ff;
   logic         chain_vld [0:N];
   logic [W-1:0] chain_acc [0:N];

   // hold operands for the whole pass
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= start;
      end
      if (start) begin
         a_ff <= a;
         b_ff <= b;
         m_ff <= m;
      end
   end

   assign chain_vld[0] = go_ff;
   assign chain_acc[0] = '0;

   // row of cells, most significant multiplier bit first
   for (genvar k = 0; k < N; k++) begin : g_cell
      mexp_cell #(.W(W)) u_cell (
         .clock (clock),
         .reset (reset),
         .vld_i (chain_vld[k]),
         .acc_i (chain_acc[k]),
         .a_i   (a_ff),
         .m_i   (m_ff),
         .bit_i (b_ff[N-1-k]),
         .vld_o (chain_vld[k+1]),
         .acc_o (chain_acc[k+1])
      );
   end

   assign done = chain_vld[N];
   assign prod = chain_acc[N];

endmodule

// ===== design/modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Raises each item's value to the public or private exponent modulo the
// modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Both modular multiplications of an
// exponent bit run side by side in two rows of max(MOD_BITS, 32) cells,
// OP_BITS being max(MOD_BITS, 32). An exponent of zero or a zero modulus
// skips the multiplications and goes straight to S_DONE. A finished
// result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
   parameter int MOD_BITS = 32,
   parameter int EXP_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: value[31:0]; req_tuser: mode[0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mexp_pkg::VALUE_BITS-1:0]  req_tdata,
   input  logic                             req_tuser,
   // rsp_tdata: result[31:0], result_byte[39:32]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mexp_pkg::RESULT_BITS+mexp_pkg::BYTE_BITS-1:0] rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [7:0]                       csr_index,
   input  logic [mexp_pkg::CSR_BITS-1:0]    csr_data
);

   import mexp_pkg::*;

   localparam int OP_BITS = (MOD_BITS > VALUE_BITS) ? MOD_BITS : VALUE_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RED,
      S_BIT,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [CSR_BITS-1:0]   modulus_ff;
   logic [CSR_BITS-1:0]   pub_exp_ff;
   logic [CSR_BITS-1:0]   priv_exp_ff;
   logic [MOD_BITS-1:0]   m_ff;
   logic [MOD_BITS-1:0]   acc_ff;
   logic [MOD_BITS-1:0]   base_ff;
   logic [EXP_BITS-1:0]   exp_ff;
   logic                  start_ff;
   logic [MOD_BITS-1:0]   x_a_ff;
   logic [OP_BITS-1:0]    x_b_ff;
   logic                  rsp_valid_ff;
   logic [RESULT_BITS-1:0] result_ff;
   logic [BYTE_BITS-1:0]  byte_ff;

   logic                  req_accept;
   logic [EXP_BITS-1:0]   exp_in;
   logic [MOD_BITS-1:0]   m_in;
   logic [EXP_BITS-1:0]   exp_next;
   logic [MOD_BITS-1:0]   acc_next;
   logic                  x_done;
   logic                  s_done;
   logic [MOD_BITS-1:0]   x_prod;
   logic [MOD_BITS-1:0]   s_prod;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign exp_in   = (req_tuser == MODE_DECRYPT) ? EXP_BITS'(priv_exp_ff)
                                                 : EXP_BITS'(pub_exp_ff);
   assign m_in     = MOD_BITS'(modulus_ff);
   assign exp_next = exp_ff >> 1;
   assign acc_next = exp_ff[0] ? x_prod : acc_ff;

   // take configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= MODULUS_RESET;
         pub_exp_ff  <= PUBLIC_EXP_RESET;
         priv_exp_ff <= PRIVATE_EXP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_MODULUS:     modulus_ff  <= csr_data;
            REG_PUBLIC_EXP:  pub_exp_ff  <= csr_data;
            REG_PRIVATE_EXP: priv_exp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequence reduction, exponent bits and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  m_ff   <= m_in;
                  exp_ff <= exp_in;
                  x_a_ff <= MOD_BITS'(1);
                  x_b_ff <= OP_BITS'(req_tdata);
                  if (exp_in == '0) begin
                     acc_ff   <= MOD_BITS'(1);
                     start_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end else if (m_in == '0) begin
                     acc_ff   <= '0;
                     start_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     acc_ff   <= MOD_BITS'(1);
                     start_ff <= 1'b1;
                     state_ff <= S_RED;
                  end
               end else begin
                  start_ff <= 1'b0;
               end
            end
            S_RED: begin
               if (x_done) begin
                  base_ff  <= x_prod;
                  x_a_ff   <= acc_ff;
                  x_b_ff   <= OP_BITS'(x_prod);
                  start_ff <= 1'b1;
                  state_ff <= S_BIT;
               end else begin
                  start_ff <= 1'b0;
               end
            end
            S_BIT: begin
               if (x_done) begin
                  acc_ff  <= acc_next;
                  base_ff <= s_prod;
                  exp_ff  <= exp_next;
                  x_a_ff  <= acc_next;
                  x_b_ff  <= OP_BITS'(s_prod);
                  if (exp_next == '0) begin
                     start_ff <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     start_ff <= 1'b1;
                  end
               end else begin
                  start_ff <= 1'b0;
               end
            end
            S_DONE: begin
               start_ff <= 1'b0;
               if (!rsp_valid_ff || rsp_tready) begin
                  result_ff    <= RESULT_BITS'(acc_ff);
                  byte_ff      <= acc_ff[BYTE_BITS-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               start_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // multiply row: reduction and acc * base
   mexp_mul_row #(.W(MOD_BITS), .N(OP_BITS)) u_row_x (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .a     (x_a_ff),
      .b     (x_b_ff),
      .m     (m_ff),
      .done  (x_done),
      .prod  (x_prod)
   );

   // square row: base * base
   mexp_mul_row #(.W(MOD_BITS), .N(OP_BITS)) u_row_s (
      .clock (clock),
      .reset (reset),
      .start (start_ff && (state_ff == S_BIT)),
      .a     (base_ff),
      .b     (OP_BITS'(base_ff)),
      .m     (m_ff),
      .done  (s_done),
      .prod  (s_prod)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {byte_ff, result_ff};

`ifndef SYNTH
   // square row never finishes without the multiply row
   a_square_with_mult : assert property (@(posedge clock) disable iff (reset)
      s_done |-> x_done)
      else $error("square row finished alone");

   // multiply row finishes only while an item is at work
   a_done_in_work : assert property (@(posedge clock) disable iff (reset)
      x_done |-> (state_ff == S_RED || state_ff == S_BIT))
      else $error("multiply row finished while idle");

   // an accepted item closes the input until its result is stored
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("input open right after accept");
`endif

endmodule

// ===== tb/tb_modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_unit
// Self-checking bench for the modular exponentiation unit. Each item is
// predicted by a shift-and-add modular power computed in the bench, queued,
// and matched against the results. Keys are changed between phases, while the
// unit is idle, and the handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_unit;
   import mexp_pkg::*;

   typedef struct packed {
      logic [31:0] result;
      logic [7:0]  result_byte;
   } power_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // bench copy of the key registers
   logic [31:0] key_modulus;
   logic [31:0] key_public;
   logic [31:0] key_private;

   power_type   power_queue[$];
   int          error_count = 0;
   int          checked_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_off = 1'b0;
   longint      cycle_count = 0;

   modular_exponentiation_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // end the run at a generous limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd3000000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // (a + b) mod m with a, b < m
   function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      if (a >= m - b) return a - (m - b);
      return a + b;
   endfunction

   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] acc;
      acc = '0;
      for (int i = 63; i >= 0; i--) begin
         acc = add_mod(acc, acc, m);
         if (b[i]) acc = add_mod(acc, a, m);
      end
      return acc;
   endfunction

   function automatic power_type predict_power(logic mode, logic [31:0] value);
      logic [63:0] m, e, base, acc;
      power_type p;
      m = 64'(key_modulus);
      e = (mode == MODE_DECRYPT) ? 64'(key_private) : 64'(key_public);
      acc = 64'd1;
      if (e != 0) begin
         if (m == 0) acc = '0;
         else begin
            base = 64'(value) % m;
            while (e != 0) begin
               if (e[0]) acc = mul_mod(acc, base, m);
               base = mul_mod(base, base, m);
               e = e >> 1;
            end
            acc = acc % m;
         end
      end
      p.result = acc[31:0];
      p.result_byte = acc[7:0];
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // drive the receiver ready
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check each accepted result against the oldest prediction
   always @(posedge clock) begin
      power_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (power_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], 32'd0);
         end else begin
            want = power_queue.pop_front();
            if (rsp_tdata[31:0] !== want.result)
               report_mismatch("result", rsp_tdata[31:0], want.result);
            if (rsp_tdata[39:32] !== want.result_byte)
               report_mismatch("result_byte", 32'(rsp_tdata[39:32]),
                               32'(want.result_byte));
            checked_count++;
         end
      end
   end

   // offer one item; valid stays high into the next item unless the sender idles
   task automatic send_item(logic mode, logic [31:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      power_queue.push_back(predict_power(mode, value));
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and wait until every expected result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (power_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_key(logic [7:0] index, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (index)
         REG_MODULUS:     key_modulus = data;
         REG_PUBLIC_EXP:  key_public = data;
         REG_PRIVATE_EXP: key_private = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_keys(logic [31:0] m, logic [31:0] e, logic [31:0] d);
      wait_drained();
      write_key(REG_MODULUS, m);
      write_key(REG_PUBLIC_EXP, e);
      write_key(REG_PRIVATE_EXP, d);
   endtask

   // reset keys, extremes of the value, round trip of a character
   task automatic test_directed();
      send_item(MODE_ENCRYPT, 32'd65);
      send_item(MODE_DECRYPT, 32'd2790);
      send_item(MODE_ENCRYPT, 32'd0);
      send_item(MODE_DECRYPT, 32'hFFFF_FFFF);
      send_item(MODE_ENCRYPT, 32'd3233);
      // zero exponent gives one, even with modulus one
      set_keys(32'd1, 32'd0, 32'd5);
      send_item(MODE_ENCRYPT, 32'd77);
      send_item(MODE_DECRYPT, 32'd77);
      // unknown register index is ignored
      wait_drained();
      write_key(8'd3, 32'hDEAD_BEEF);
      // all-ones modulus and exponents
      set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(MODE_ENCRYPT, 32'hFFFF_FFFE);
      send_item(MODE_DECRYPT, 32'h8000_0001);
      send_item(MODE_ENCRYPT, 32'hFFFF_FFFF);
      // zero modulus, outside range
      set_keys(32'd0, 32'd7, 32'd0);
      send_item(MODE_ENCRYPT, 32'd9);
      send_item(MODE_DECRYPT, 32'd9);
      set_keys(32'd3233, 32'd17, 32'd2753);
   endtask

   task automatic test_random(int count);
      logic [31:0] v;
      for (int i = 0; i < count; i++) begin
         v = $urandom();
         if ($urandom_range(3) == 0) v = $urandom_range(255);
         send_item(1'($urandom_range(1)), v);
      end
   endtask

   // fill the unit while the receiver holds off
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (6000) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(6);
      join
      wait_drained();
   endtask

   task automatic random_phase(int p, int count);
      logic [31:0] m;
      m = (p % 3 == 0) ? $urandom() : $urandom_range(1, 65535);
      set_keys(m, (p == 1) ? 32'd3 : $urandom(), $urandom() >> $urandom_range(31));
      test_random(count);
   endtask

   initial begin
      key_modulus = MODULUS_RESET;
      key_public  = PUBLIC_EXP_RESET;
      key_private = PRIVATE_EXP_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 29;
      recv_idle_pct = 46;
      test_directed();
      for (int p = 0; p < 3; p++) random_phase(p, 30);
      send_idle_pct = 46;
      recv_idle_pct = 29;
      for (int p = 3; p < 6; p++) random_phase(p, 30);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int p = 6; p < 9; p++) random_phase(p, 30);
      wait_drained();
      repeat (2200) @(posedge clock);
      $display("Covered %0d results over reset, extreme and random keys,", checked_count);
      $display("both modes, random idling and a long receiver stall.");
      if (error_count == 0 && power_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
